### design/crgs_pkg.sv
// crgs_pkg: shared types, constants and helper functions of the crop-resize
// gradient scatter unit. No dependencies; used by every other design file except crgs_ram.

package crgs_pkg;

   localparam int MAX_EXTENT   = 16;
   localparam int MAX_CROP     = 16;
   localparam int MAX_CHANNELS = 8;

   localparam int STORE_AW   = 16;
   localparam int STORE_DW   = 32;
   localparam int COORD_W    = 18;
   localparam int GRAD_W     = 24;
   localparam int ORG_W      = 24;
   localparam int IDX_W      = 4;
   localparam int CNT_W      = 4;
   localparam int CH_W       = 3;
   localparam int EXT_W      = 5;
   localparam int FRAC_W     = 16;
   localparam int WGT_W      = 17;
   localparam int MUL_A_W    = 27;
   localparam int MUL_B_W    = 18;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int POS_W      = 30;
   localparam int DIV_W      = 24;
   localparam int DVS_W      = 4;
   localparam int CONTRIB_W  = 26;
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 5;
   localparam int CFG_COUNT  = 8;
   localparam int OP_W       = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_BOX = 2'd0,
      OP_GRADIENT = 2'd1,
      OP_READ     = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_DEPTH  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_CROP_HEIGHT  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_CROP_WIDTH   = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_CROP_DEPTH   = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS     = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_NEAREST_MODE = 3'd7;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BOX_ORG,
      ST_BOX_ORG_W,
      ST_BOX_STEP,
      ST_BOX_DIV,
      ST_BOX_DIV_W,
      ST_POS,
      ST_POS_W,
      ST_W1,
      ST_W1_R,
      ST_W2,
      ST_W2_R,
      ST_GMUL,
      ST_GMUL_R,
      ST_ADDR,
      ST_ADDR_R,
      ST_RD,
      ST_RD_W,
      ST_READ,
      ST_READ_W,
      ST_RESP
   } state_type;

   function automatic logic [CFG_DATA_W-1:0] cfg_mask(input logic [CFG_IDX_W-1:0] idx);
      logic [CFG_DATA_W-1:0] m;
      case (idx)
         CFG_CHANNELS:     m = 5'd15;
         CFG_NEAREST_MODE: m = 5'd1;
         default:          m = 5'd31;
      endcase
      return m;
   endfunction

   function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] v,
                                                  input logic [EXT_W-1:0] hi);
      logic [EXT_W-1:0] r;
      if (v == '0) r = EXT_W'(1);
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

   function automatic logic signed [ORG_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
      logic signed [ORG_W-1:0] r;
      if (v > PROD_W'(signed'(8388607))) r = 24'sh7fffff;
      else if (v < -PROD_W'(signed'(8388608))) r = 24'sh800000;
      else r = v[ORG_W-1:0];
      return r;
   endfunction

   function automatic logic signed [PROD_W-1:0] half_round(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] mag;
      logic signed [PROD_W-1:0] q;
      mag = v[PROD_W-1] ? -v : v;
      q = (mag + PROD_W'(1)) >>> 1;
      return v[PROD_W-1] ? -q : q;
   endfunction

endpackage

### design/crgs_if.sv
// crgs_req_if / crgs_rsp_if: valid-ready request and response channels.
// Depends on crgs_pkg for field widths.

interface crgs_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [crgs_pkg::OP_W-1:0]                 operation;
   logic signed [crgs_pkg::COORD_W-1:0]       box_y_start;
   logic signed [crgs_pkg::COORD_W-1:0]       box_x_start;
   logic signed [crgs_pkg::COORD_W-1:0]       box_z_start;
   logic signed [crgs_pkg::COORD_W-1:0]       box_y_end;
   logic signed [crgs_pkg::COORD_W-1:0]       box_x_end;
   logic signed [crgs_pkg::COORD_W-1:0]       box_z_end;
   logic                                      batch_index;
   logic signed [crgs_pkg::GRAD_W-1:0]        gradient;
   logic [crgs_pkg::STORE_AW-1:0]             voxel_address;

   modport source (output valid, operation, box_y_start, box_x_start, box_z_start,
                   box_y_end, box_x_end, box_z_end, batch_index, gradient,
                   voxel_address, input ready);
   modport sink (input valid, operation, box_y_start, box_x_start, box_z_start,
                 box_y_end, box_x_end, box_z_end, batch_index, gradient,
                 voxel_address, output ready);
endinterface

interface crgs_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [crgs_pkg::STORE_DW-1:0] read_value;
   logic                                 skipped;
   logic                                 box_done;

   modport source (output valid, read_value, skipped, box_done, input ready);
   modport sink (input valid, read_value, skipped, box_done, output ready);
endinterface

### design/crgs_ram.sv
// crgs_ram: generic single-port RAM with registered read.
// No dependencies.

module crgs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### design/crgs_div.sv
// crgs_div: restoring divider, one quotient bit per cycle.
// Depends on crgs_pkg for widths.

module crgs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [crgs_pkg::DIV_W-1:0]    dividend,
   input  logic [crgs_pkg::DVS_W-1:0]    divisor,
   output logic [crgs_pkg::DIV_W-1:0]    quotient,
   output logic                          done
);

   localparam int BIT_W = $clog2(crgs_pkg::DIV_W + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [BIT_W-1:0]              bit_ff, bit_in;
   logic [crgs_pkg::DIV_W-1:0]    dvd_ff, dvd_in;
   logic [crgs_pkg::DVS_W-1:0]    rem_ff, rem_in;
   logic [crgs_pkg::DVS_W-1:0]    dvs_ff, dvs_in;
   logic [crgs_pkg::DVS_W:0]      shifted;
   logic                          qbit;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, dvd_ff[crgs_pkg::DIV_W-1]};
      qbit    = shifted >= {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         bit_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = qbit ? crgs_pkg::DVS_W'(shifted - {1'b0, dvs_ff})
                       : crgs_pkg::DVS_W'(shifted);
         dvd_in = {dvd_ff[crgs_pkg::DIV_W-2:0], qbit};
         bit_in = bit_ff + BIT_W'(1);
         if (bit_ff == BIT_W'(crgs_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bit_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         bit_ff  <= bit_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = dvd_ff;
   assign done     = done_ff;

endmodule

### design/crop_resize_3d_grad_scatter_unit.sv
// crop_resize_3d_grad_scatter_unit: top level with sequencer, shared multiplier
// and accumulation store. Depends on crgs_pkg, crgs_if, crgs_ram, crgs_div.
//
// One request is worked at a time by a sequencer around a single shared
// multiplier and one single-port accumulator memory (registered read). A
// gradient request in trilinear mode computes the sample position, then for
// each of the eight corners two weight products, the gradient product, four
// address products and a read-modify-write; nearest mode does the address
// products and read-modify-write of one corner only. A box load computes an
// origin per axis and, with the bit-serial divider, a step for each axis whose
// crop extent exceeds one. A clear request and the clearing pass after reset
// sweep the whole store at one entry per cycle, with no request taken.

module crop_resize_3d_grad_scatter_unit (
   input  logic                                clock,
   input  logic                                reset,
   crgs_req_if.sink                            req_bus,
   crgs_rsp_if.source                          rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [crgs_pkg::CFG_IDX_W-1:0]      csr_index,
   input  logic [crgs_pkg::CFG_DATA_W-1:0]     csr_write_data
);

   localparam int AW = crgs_pkg::STORE_AW;
   localparam int DW = crgs_pkg::STORE_DW;
   localparam int PW = crgs_pkg::PROD_W;

   crgs_pkg::state_type state_ff, state_in;

   logic [crgs_pkg::CFG_DATA_W-1:0] cfg_ff [crgs_pkg::CFG_COUNT];

   logic signed [crgs_pkg::COORD_W-1:0]  s_ff [3];
   logic signed [crgs_pkg::COORD_W-1:0]  t_ff [3];
   logic                                 bidx_ff;
   logic signed [crgs_pkg::GRAD_W-1:0]   grad_ff;
   logic [AW-1:0]                        vaddr_ff;

   logic signed [crgs_pkg::ORG_W-1:0]    origin_ff [3];
   logic signed [crgs_pkg::ORG_W-1:0]    origin_in [3];
   logic signed [crgs_pkg::ORG_W-1:0]    step_ff [3];
   logic signed [crgs_pkg::ORG_W-1:0]    step_in [3];
   logic [crgs_pkg::CNT_W-1:0]           cnt_ff [3];
   logic [crgs_pkg::CNT_W-1:0]           cnt_in [3];
   logic [crgs_pkg::CH_W-1:0]            chan_ff, chan_in;
   logic                                 batch_ff, batch_in;

   logic [1:0]                           ax_ff, ax_in;
   logic                                 sign_ff, sign_in;
   logic                                 skip_ff, skip_in;
   logic [crgs_pkg::IDX_W-1:0]           lo_ff [3];
   logic [crgs_pkg::IDX_W-1:0]           lo_in [3];
   logic [crgs_pkg::FRAC_W-1:0]          frac_ff [3];
   logic [crgs_pkg::FRAC_W-1:0]          frac_in [3];
   logic [2:0]                           corner_ff, corner_in;
   logic [crgs_pkg::WGT_W-1:0]           wyx_ff, wyx_in;
   logic [crgs_pkg::WGT_W-1:0]           w_ff, w_in;
   logic signed [crgs_pkg::CONTRIB_W-1:0] contrib_ff, contrib_in;
   logic [AW-1:0]                        addr_ff, addr_in;
   logic [1:0]                           astep_ff, astep_in;
   logic [AW-1:0]                        clr_ff, clr_in;
   logic                                 clr_op_ff, clr_op_in;
   logic signed [PW-1:0]                 prod_ff, prod_in;

   logic signed [DW-1:0]                 res_value_ff, res_value_in;
   logic                                 res_skip_ff, res_skip_in;
   logic                                 res_done_ff, res_done_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]                 rsp_value_ff, rsp_value_in;
   logic                                 rsp_skip_ff, rsp_skip_in;
   logic                                 rsp_done_ff, rsp_done_in;

   logic signed [crgs_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [crgs_pkg::MUL_B_W-1:0]  mul_b;

   logic [crgs_pkg::EXT_W-1:0]           img_eff [3];
   logic [crgs_pkg::EXT_W-1:0]           crop_eff [3];
   logic [crgs_pkg::EXT_W-1:0]           chan_eff;
   logic                                 nearest;
   logic [crgs_pkg::EXT_W-1:0]           e_sel;
   logic                                 multi;
   logic                                 req_fire;
   logic                                 rsp_free;
   logic                                 last_ax;

   logic                                 ram_we;
   logic [AW-1:0]                        ram_addr;
   logic [DW-1:0]                        ram_wdata;
   logic [DW-1:0]                        ram_rdata;

   logic                                 div_start;
   logic [crgs_pkg::DIV_W-1:0]           div_dividend;
   logic [crgs_pkg::DVS_W-1:0]           div_divisor;
   logic [crgs_pkg::DIV_W-1:0]           div_quotient;
   logic                                 div_done;

   logic signed [crgs_pkg::COORD_W:0]    st_sum;
   logic signed [crgs_pkg::COORD_W:0]    st_diff;
   logic signed [crgs_pkg::POS_W-1:0]    pos;
   logic signed [crgs_pkg::POS_W-1:0]    pos_near;
   logic signed [crgs_pkg::POS_W-1:0]    pos_max;
   logic                                 out_now;
   logic signed [PW-1:0]                 prod_rnd;
   logic signed [PW-1:0]                 prod_mag;
   logic signed [PW-1:0]                 quot_signed;
   logic [crgs_pkg::WGT_W-1:0]           wy, wx, wz;
   logic [crgs_pkg::IDX_W-1:0]           hi [3];
   logic [crgs_pkg::EXT_W-1:0]           ext_sel;
   logic [crgs_pkg::IDX_W-1:0]           idx_sel;
   logic signed [DW:0]                   acc_sum;
   logic signed [DW-1:0]                 acc_sat;

   logic [crgs_pkg::CNT_W-1:0]           adv_cnt [3];
   logic [crgs_pkg::CH_W-1:0]            adv_chan;
   logic                                 adv_wrap;
   logic [crgs_pkg::EXT_W-1:0]           c_inc;
   logic [crgs_pkg::EXT_W-1:0]           k_inc;

   crgs_ram #(.WIDTH(DW), .DEPTH(2 ** AW)) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   crgs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // effective register values
   always_comb begin
      img_eff[0]  = crgs_pkg::clamp_ext(cfg_ff[crgs_pkg::CFG_IMAGE_HEIGHT],
                                        crgs_pkg::EXT_W'(crgs_pkg::MAX_EXTENT));
      img_eff[1]  = crgs_pkg::clamp_ext(cfg_ff[crgs_pkg::CFG_IMAGE_WIDTH],
                                        crgs_pkg::EXT_W'(crgs_pkg::MAX_EXTENT));
      img_eff[2]  = crgs_pkg::clamp_ext(cfg_ff[crgs_pkg::CFG_IMAGE_DEPTH],
                                        crgs_pkg::EXT_W'(crgs_pkg::MAX_EXTENT));
      crop_eff[0] = crgs_pkg::clamp_ext(cfg_ff[crgs_pkg::CFG_CROP_HEIGHT],
                                        crgs_pkg::EXT_W'(crgs_pkg::MAX_CROP));
      crop_eff[1] = crgs_pkg::clamp_ext(cfg_ff[crgs_pkg::CFG_CROP_WIDTH],
                                        crgs_pkg::EXT_W'(crgs_pkg::MAX_CROP));
      crop_eff[2] = crgs_pkg::clamp_ext(cfg_ff[crgs_pkg::CFG_CROP_DEPTH],
                                        crgs_pkg::EXT_W'(crgs_pkg::MAX_CROP));
      chan_eff    = crgs_pkg::clamp_ext(cfg_ff[crgs_pkg::CFG_CHANNELS],
                                        crgs_pkg::EXT_W'(crgs_pkg::MAX_CHANNELS));
      nearest     = cfg_ff[crgs_pkg::CFG_NEAREST_MODE][0];
   end

   assign req_fire = req_bus.valid && (state_ff == crgs_pkg::ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign last_ax  = (ax_ff == 2'd2);
   assign e_sel    = img_eff[ax_ff] - crgs_pkg::EXT_W'(1);
   assign multi    = crop_eff[ax_ff] > crgs_pkg::EXT_W'(1);

   // shared datapath helpers
   always_comb begin
      st_sum   = (crgs_pkg::COORD_W+1)'(s_ff[ax_ff]) + (crgs_pkg::COORD_W+1)'(t_ff[ax_ff]);
      st_diff  = (crgs_pkg::COORD_W+1)'(t_ff[ax_ff]) - (crgs_pkg::COORD_W+1)'(s_ff[ax_ff]);
      pos      = crgs_pkg::POS_W'(origin_ff[ax_ff]) + crgs_pkg::POS_W'(prod_ff);
      pos_near = pos + crgs_pkg::POS_W'(32768);
      pos_max  = crgs_pkg::POS_W'({1'b0, e_sel, 16'h0000});
      out_now  = pos[crgs_pkg::POS_W-1] || (pos > pos_max);
      prod_rnd = prod_ff + PW'(32768);
      prod_mag = prod_ff[PW-1] ? -prod_ff : prod_ff;
      quot_signed = sign_ff ? -PW'({1'b0, div_quotient}) : PW'({1'b0, div_quotient});
      wy = corner_ff[2] ? {1'b0, frac_ff[0]} : crgs_pkg::WGT_W'(17'h10000 - {1'b0, frac_ff[0]});
      wx = corner_ff[1] ? {1'b0, frac_ff[1]} : crgs_pkg::WGT_W'(17'h10000 - {1'b0, frac_ff[1]});
      wz = corner_ff[0] ? {1'b0, frac_ff[2]} : crgs_pkg::WGT_W'(17'h10000 - {1'b0, frac_ff[2]});
      for (int a = 0; a < 3; a++) begin
         hi[a] = lo_ff[a] + crgs_pkg::IDX_W'(frac_ff[a] != '0);
      end
      case (astep_ff)
         2'd0: begin
            ext_sel = img_eff[0];
            idx_sel = corner_ff[2] ? hi[0] : lo_ff[0];
         end
         2'd1: begin
            ext_sel = img_eff[1];
            idx_sel = corner_ff[1] ? hi[1] : lo_ff[1];
         end
         2'd2: begin
            ext_sel = img_eff[2];
            idx_sel = corner_ff[0] ? hi[2] : lo_ff[2];
         end
         default: begin
            ext_sel = chan_eff;
            idx_sel = crgs_pkg::IDX_W'(chan_ff);
         end
      endcase
      acc_sum = (DW+1)'($signed(ram_rdata)) + (DW+1)'(contrib_ff);
      if (acc_sum[DW] != acc_sum[DW-1]) begin
         acc_sat = acc_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
         acc_sat = acc_sum[DW-1:0];
      end
   end

   // counter advance after a gradient request
   always_comb begin
      logic carry;
      carry    = 1'b0;
      c_inc    = crgs_pkg::EXT_W'(chan_ff) + crgs_pkg::EXT_W'(1);
      adv_cnt  = cnt_ff;
      if (c_inc < chan_eff) begin
         adv_chan = crgs_pkg::CH_W'(c_inc);
      end else begin
         adv_chan = '0;
         carry    = 1'b1;
      end
      for (int a = 2; a >= 0; a--) begin
         k_inc = crgs_pkg::EXT_W'(cnt_ff[a]) + crgs_pkg::EXT_W'(1);
         if (carry) begin
            if (k_inc < crop_eff[a]) begin
               adv_cnt[a] = crgs_pkg::CNT_W'(k_inc);
               carry      = 1'b0;
            end else begin
               adv_cnt[a] = '0;
            end
         end
      end
      adv_wrap = carry;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crgs_pkg::ST_CLEAR: begin
            if (clr_ff == '1) state_in = clr_op_ff ? crgs_pkg::ST_RESP : crgs_pkg::ST_IDLE;
         end
         crgs_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (crgs_pkg::op_type'(req_bus.operation))
                  crgs_pkg::OP_LOAD_BOX: state_in = crgs_pkg::ST_BOX_ORG;
                  crgs_pkg::OP_GRADIENT: state_in = crgs_pkg::ST_POS;
                  crgs_pkg::OP_READ:     state_in = crgs_pkg::ST_READ;
                  default:               state_in = crgs_pkg::ST_CLEAR;
               endcase
            end
         end
         crgs_pkg::ST_BOX_ORG:   state_in = crgs_pkg::ST_BOX_ORG_W;
         crgs_pkg::ST_BOX_ORG_W: begin
            if (multi) state_in = crgs_pkg::ST_BOX_STEP;
            else state_in = last_ax ? crgs_pkg::ST_RESP : crgs_pkg::ST_BOX_ORG;
         end
         crgs_pkg::ST_BOX_STEP:  state_in = crgs_pkg::ST_BOX_DIV;
         crgs_pkg::ST_BOX_DIV:   state_in = crgs_pkg::ST_BOX_DIV_W;
         crgs_pkg::ST_BOX_DIV_W: begin
            if (div_done) state_in = last_ax ? crgs_pkg::ST_RESP : crgs_pkg::ST_BOX_ORG;
         end
         crgs_pkg::ST_POS:       state_in = crgs_pkg::ST_POS_W;
         crgs_pkg::ST_POS_W: begin
            if (!last_ax) state_in = crgs_pkg::ST_POS;
            else if (skip_ff || out_now) state_in = crgs_pkg::ST_RESP;
            else state_in = nearest ? crgs_pkg::ST_ADDR : crgs_pkg::ST_W1;
         end
         crgs_pkg::ST_W1:        state_in = crgs_pkg::ST_W1_R;
         crgs_pkg::ST_W1_R:      state_in = crgs_pkg::ST_W2;
         crgs_pkg::ST_W2:        state_in = crgs_pkg::ST_W2_R;
         crgs_pkg::ST_W2_R:      state_in = crgs_pkg::ST_GMUL;
         crgs_pkg::ST_GMUL:      state_in = crgs_pkg::ST_GMUL_R;
         crgs_pkg::ST_GMUL_R:    state_in = crgs_pkg::ST_ADDR;
         crgs_pkg::ST_ADDR:      state_in = crgs_pkg::ST_ADDR_R;
         crgs_pkg::ST_ADDR_R: begin
            state_in = (astep_ff == 2'd3) ? crgs_pkg::ST_RD : crgs_pkg::ST_ADDR;
         end
         crgs_pkg::ST_RD:        state_in = crgs_pkg::ST_RD_W;
         crgs_pkg::ST_RD_W: begin
            state_in = (nearest || corner_ff == 3'd7) ? crgs_pkg::ST_RESP : crgs_pkg::ST_W1;
         end
         crgs_pkg::ST_READ:      state_in = crgs_pkg::ST_READ_W;
         crgs_pkg::ST_READ_W:    state_in = crgs_pkg::ST_RESP;
         crgs_pkg::ST_RESP: begin
            if (rsp_free) state_in = crgs_pkg::ST_IDLE;
         end
         default:                state_in = crgs_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      origin_in    = origin_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      chan_in      = chan_ff;
      batch_in     = batch_ff;
      ax_in        = ax_ff;
      sign_in      = sign_ff;
      skip_in      = skip_ff;
      lo_in        = lo_ff;
      frac_in      = frac_ff;
      corner_in    = corner_ff;
      wyx_in       = wyx_ff;
      w_in         = w_ff;
      contrib_in   = contrib_ff;
      addr_in      = addr_ff;
      astep_in     = astep_ff;
      clr_in       = clr_ff;
      clr_op_in    = clr_op_ff;
      res_value_in = res_value_ff;
      res_skip_in  = res_skip_ff;
      res_done_in  = res_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in = rsp_value_ff;
      rsp_skip_in  = rsp_skip_ff;
      rsp_done_in  = rsp_done_ff;
      mul_a        = '0;
      mul_b        = '0;
      ram_we       = 1'b0;
      ram_addr     = addr_ff;
      ram_wdata    = acc_sat;
      div_start    = 1'b0;
      div_dividend = crgs_pkg::DIV_W'(prod_mag) + crgs_pkg::DIV_W'((crop_eff[ax_ff]
                     - crgs_pkg::EXT_W'(1)) >> 1);
      div_divisor  = crgs_pkg::DVS_W'(crop_eff[ax_ff] - crgs_pkg::EXT_W'(1));

      case (state_ff)
         crgs_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            res_value_in = '0;
            res_skip_in  = 1'b0;
            res_done_in  = 1'b0;
         end
         crgs_pkg::ST_IDLE: begin
            if (req_fire) begin
               ax_in     = '0;
               skip_in   = 1'b0;
               clr_in    = '0;
               clr_op_in = 1'b1;
            end
         end
         crgs_pkg::ST_BOX_ORG: begin
            mul_a = multi ? crgs_pkg::MUL_A_W'(s_ff[ax_ff]) : crgs_pkg::MUL_A_W'(st_sum);
            mul_b = crgs_pkg::MUL_B_W'({1'b0, e_sel});
         end
         crgs_pkg::ST_BOX_ORG_W: begin
            if (multi) begin
               origin_in[ax_ff] = crgs_pkg::sat24(prod_ff);
            end else begin
               origin_in[ax_ff] = crgs_pkg::sat24(crgs_pkg::half_round(prod_ff));
               step_in[ax_ff]   = '0;
               ax_in            = ax_ff + 2'd1;
            end
         end
         crgs_pkg::ST_BOX_STEP: begin
            mul_a = crgs_pkg::MUL_A_W'(st_diff);
            mul_b = crgs_pkg::MUL_B_W'({1'b0, e_sel});
         end
         crgs_pkg::ST_BOX_DIV: begin
            div_start = 1'b1;
            sign_in   = prod_ff[PW-1];
         end
         crgs_pkg::ST_BOX_DIV_W: begin
            if (div_done) begin
               step_in[ax_ff] = crgs_pkg::sat24(quot_signed);
               ax_in          = ax_ff + 2'd1;
            end
         end
         crgs_pkg::ST_POS: begin
            mul_a = crgs_pkg::MUL_A_W'(step_ff[ax_ff]);
            mul_b = crgs_pkg::MUL_B_W'({1'b0, cnt_ff[ax_ff]});
         end
         crgs_pkg::ST_POS_W: begin
            skip_in          = skip_ff || out_now;
            lo_in[ax_ff]     = nearest ? pos_near[19:16] : pos[19:16];
            frac_in[ax_ff]   = pos[15:0];
            ax_in            = ax_ff + 2'd1;
            corner_in        = '0;
            contrib_in       = crgs_pkg::CONTRIB_W'(grad_ff);
            addr_in          = AW'(batch_ff);
            astep_in         = '0;
         end
         crgs_pkg::ST_W1: begin
            mul_a = crgs_pkg::MUL_A_W'({1'b0, wy});
            mul_b = crgs_pkg::MUL_B_W'({1'b0, wx});
         end
         crgs_pkg::ST_W1_R: begin
            wyx_in = prod_rnd[32:16];
         end
         crgs_pkg::ST_W2: begin
            mul_a = crgs_pkg::MUL_A_W'({1'b0, wyx_ff});
            mul_b = crgs_pkg::MUL_B_W'({1'b0, wz});
         end
         crgs_pkg::ST_W2_R: begin
            w_in = prod_rnd[32:16];
         end
         crgs_pkg::ST_GMUL: begin
            mul_a = crgs_pkg::MUL_A_W'(grad_ff);
            mul_b = crgs_pkg::MUL_B_W'({1'b0, w_ff});
         end
         crgs_pkg::ST_GMUL_R: begin
            contrib_in = prod_rnd[41:16];
            addr_in    = AW'(batch_ff);
            astep_in   = '0;
         end
         crgs_pkg::ST_ADDR: begin
            mul_a = crgs_pkg::MUL_A_W'({1'b0, addr_ff});
            mul_b = crgs_pkg::MUL_B_W'({1'b0, ext_sel});
         end
         crgs_pkg::ST_ADDR_R: begin
            addr_in  = prod_ff[AW-1:0] + AW'(idx_sel);
            astep_in = astep_ff + 2'd1;
         end
         crgs_pkg::ST_RD: begin
            ram_addr = addr_ff;
         end
         crgs_pkg::ST_RD_W: begin
            ram_we    = 1'b1;
            ram_addr  = addr_ff;
            ram_wdata = acc_sat;
            corner_in = corner_ff + 3'd1;
         end
         crgs_pkg::ST_READ: begin
            ram_addr = vaddr_ff;
         end
         crgs_pkg::ST_READ_W: begin
            res_value_in = ram_rdata;
            res_skip_in  = 1'b0;
            res_done_in  = 1'b0;
         end
         crgs_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_skip_in  = res_skip_ff;
               rsp_done_in  = res_done_ff;
            end
         end
         default: begin
         end
      endcase

      // box load finished
      if ((state_ff == crgs_pkg::ST_BOX_ORG_W && !multi && last_ax) ||
          (state_ff == crgs_pkg::ST_BOX_DIV_W && div_done && last_ax)) begin
         for (int a = 0; a < 3; a++) cnt_in[a] = '0;
         chan_in      = '0;
         batch_in     = bidx_ff;
         res_value_in = '0;
         res_skip_in  = 1'b0;
         res_done_in  = 1'b0;
      end

      // gradient request finished
      if ((state_ff == crgs_pkg::ST_POS_W && last_ax && (skip_ff || out_now)) ||
          (state_ff == crgs_pkg::ST_RD_W && (nearest || corner_ff == 3'd7))) begin
         cnt_in       = adv_cnt;
         chan_in      = adv_chan;
         res_value_in = '0;
         res_skip_in  = (state_ff == crgs_pkg::ST_POS_W);
         res_done_in  = adv_wrap;
      end
   end

   assign prod_in = PW'(mul_a) * PW'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crgs_pkg::ST_CLEAR;
         clr_ff       <= '0;
         clr_op_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff[crgs_pkg::CFG_IMAGE_HEIGHT] <= crgs_pkg::CFG_DATA_W'(16);
         cfg_ff[crgs_pkg::CFG_IMAGE_WIDTH]  <= crgs_pkg::CFG_DATA_W'(16);
         cfg_ff[crgs_pkg::CFG_IMAGE_DEPTH]  <= crgs_pkg::CFG_DATA_W'(16);
         cfg_ff[crgs_pkg::CFG_CROP_HEIGHT]  <= crgs_pkg::CFG_DATA_W'(16);
         cfg_ff[crgs_pkg::CFG_CROP_WIDTH]   <= crgs_pkg::CFG_DATA_W'(16);
         cfg_ff[crgs_pkg::CFG_CROP_DEPTH]   <= crgs_pkg::CFG_DATA_W'(16);
         cfg_ff[crgs_pkg::CFG_CHANNELS]     <= crgs_pkg::CFG_DATA_W'(1);
         cfg_ff[crgs_pkg::CFG_NEAREST_MODE] <= '0;
         for (int a = 0; a < 3; a++) begin
            origin_ff[a] <= '0;
            step_ff[a]   <= '0;
            cnt_ff[a]    <= '0;
         end
         chan_ff      <= '0;
         batch_ff     <= 1'b0;
         ax_ff        <= '0;
         corner_ff    <= '0;
         astep_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_op_ff    <= clr_op_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            cfg_ff[csr_index] <= csr_write_data & crgs_pkg::cfg_mask(csr_index);
         end
         origin_ff    <= origin_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         chan_ff      <= chan_in;
         batch_ff     <= batch_in;
         ax_ff        <= ax_in;
         corner_ff    <= corner_in;
         astep_ff     <= astep_in;
      end
      if (req_fire) begin
         s_ff[0]  <= req_bus.box_y_start;
         s_ff[1]  <= req_bus.box_x_start;
         s_ff[2]  <= req_bus.box_z_start;
         t_ff[0]  <= req_bus.box_y_end;
         t_ff[1]  <= req_bus.box_x_end;
         t_ff[2]  <= req_bus.box_z_end;
         bidx_ff  <= req_bus.batch_index;
         grad_ff  <= req_bus.gradient;
         vaddr_ff <= req_bus.voxel_address;
      end
      sign_ff      <= sign_in;
      skip_ff      <= skip_in;
      lo_ff        <= lo_in;
      frac_ff      <= frac_in;
      wyx_ff       <= wyx_in;
      w_ff         <= w_in;
      contrib_ff   <= contrib_in;
      addr_ff      <= addr_in;
      prod_ff      <= prod_in;
      res_value_ff <= res_value_in;
      res_skip_ff  <= res_skip_in;
      res_done_ff  <= res_done_in;
      rsp_value_ff <= rsp_value_in;
      rsp_skip_ff  <= rsp_skip_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign req_bus.ready       = (state_ff == crgs_pkg::ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.read_value  = rsp_value_ff;
   assign rsp_bus.skipped     = rsp_skip_ff;
   assign rsp_bus.box_done    = rsp_done_ff;

endmodule
